// ===== rtl/sact_pkg.sv =====
// Shared types, codes and defaults for the set-associative tag directory.
`default_nettype none
package sact_pkg;

  // Default build parameters
  localparam int DEF_WAYS      = 4;
  localparam int DEF_SETS      = 64;
  localparam int DEF_ADDR_BITS = 32;

  // Fixed field widths
  localparam int ADDR_W  = 32;
  localparam int TAG_W   = 32;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 32;
  localparam int LFSR_W  = 16;

  // Configuration port layout
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLICY = 2'd0,
    CFG_OFFSET = 2'd1,
    CFG_INDEX  = 2'd2
  } sact_cfg_idx_t;

  // Replacement policy codes; any other code acts as random
  localparam logic [1:0] POL_LRU    = 2'd0;
  localparam logic [1:0] POL_FIFO   = 2'd1;
  localparam logic [1:0] POL_RANDOM = 2'd2;

  // Register reset values
  localparam logic [1:0] RST_POLICY = POL_LRU;
  localparam logic [3:0] RST_OFFSET = 4'd4;
  localparam logic [2:0] RST_INDEX  = 3'd6;

  // Galois LFSR
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

  // One way of a set as kept in the tag RAM
  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } sact_line_t;

  // Lookup outcome flags
  typedef struct packed {
    logic hit;
    logic evicted;
    logic rand_step;
  } sact_sel_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } sact_state_t;

endpackage
`default_nettype wire

// ===== rtl/sact_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module sact_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic                                    rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sact_addr_split.sv =====
// Splits an access address into set index and tag by the configured widths.
`default_nettype none
module sact_addr_split #(
  parameter int SETS      = sact_pkg::DEF_SETS,
  parameter int ADDR_BITS = sact_pkg::DEF_ADDR_BITS
) (
  input  wire logic [sact_pkg::ADDR_W-1:0]          address,
  input  wire logic [3:0]                           offset_bits,
  input  wire logic [2:0]                           index_bits,
  output logic      [((SETS > 1) ? $clog2(SETS) : 1)-1:0] set_idx,
  output logic      [sact_pkg::TAG_W-1:0]           tag
);
  import sact_pkg::*;

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int KMAX  = $clog2(SETS + 1) - 1;
  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

  logic [ADDR_W-1:0] addr_m;
  logic [2:0]        k_eff;
  logic [ADDR_W-1:0] idx_mask;
  logic [ADDR_W-1:0] set_full;
  logic [4:0]        tag_sh;

  always_comb begin
    addr_m   = address & ADDR_MASK;
    // Clamp index width to the sets that exist
    k_eff    = (32'(index_bits) > KMAX) ? 3'(KMAX) : index_bits;
    idx_mask = (ADDR_W'(1) << k_eff) - ADDR_W'(1);
    set_full = (addr_m >> offset_bits) & idx_mask;
    set_idx  = set_full[SET_W-1:0];
    tag_sh   = {1'b0, offset_bits} + {2'b00, k_eff};
    tag      = TAG_W'(addr_m >> tag_sh);
  end

endmodule
`default_nettype wire

// ===== rtl/sact_victim.sv =====
// Tag compare over one set and choice of the way to hit, fill or evict.
`default_nettype none
module sact_victim #(
  parameter int WAYS = sact_pkg::DEF_WAYS
) (
  input  wire sact_pkg::sact_line_t [WAYS-1:0]           row,
  input  wire logic [sact_pkg::TAG_W-1:0]                tag,
  input  wire logic [1:0]                                policy,
  input  wire logic [sact_pkg::LFSR_W-1:0]               lfsr_cur,
  output sact_pkg::sact_sel_t                            sel,
  output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0]     victim,
  output logic [sact_pkg::LFSR_W-1:0]                    lfsr_step
);
  import sact_pkg::*;

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int P     = 1 << $clog2(WAYS);
  localparam int RECIP = 65536 / WAYS;

  logic               hit;
  logic [WAY_W-1:0]   hit_way;
  logic               has_free;
  logic [WAY_W-1:0]   free_way;
  logic [STAMP_W-1:0] node_stamp [2*P-1];
  logic [WAY_W-1:0]   node_way   [2*P-1];
  logic [WAY_W-1:0]   min_way;
  logic [32:0]        prod;
  logic [16:0]        quot;
  logic [20:0]        rem;
  logic [WAY_W-1:0]   rand_way;
  logic               full;

  // Find the first matching valid way and the first invalid way
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    has_free = 1'b0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row[w].valid && (row[w].tag == tag)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!row[w].valid) begin
        has_free = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  // Minimum stamp by a compare tree; ties keep the lower way
  always_comb begin
    for (int j = 0; j < P; j++) begin
      node_stamp[P-1+j] = (j < WAYS) ? row[j].stamp : {STAMP_W{1'b1}};
      node_way[P-1+j]   = WAY_W'(j);
    end
    for (int i = P - 2; i >= 0; i--) begin
      if (node_stamp[2*i+2] < node_stamp[2*i+1]) begin
        node_stamp[i] = node_stamp[2*i+2];
        node_way[i]   = node_way[2*i+2];
      end else begin
        node_stamp[i] = node_stamp[2*i+1];
        node_way[i]   = node_way[2*i+1];
      end
    end
    min_way = node_way[0];
  end

  // Step the LFSR and reduce the new value modulo the way count
  always_comb begin
    lfsr_step = {1'b0, lfsr_cur[LFSR_W-1:1]} ^ (lfsr_cur[0] ? LFSR_TAPS : '0);
    prod      = 33'(lfsr_step) * 33'(RECIP);
    quot      = prod[32:16];
    rem       = 21'(lfsr_step) - 21'(21'(quot) * 21'(WAYS));
    if (rem >= 21'(WAYS)) begin
      rem = rem - 21'(WAYS);
    end
    rand_way = rem[WAY_W-1:0];
  end

  // Pick the way
  always_comb begin
    full          = !hit && !has_free;
    sel.hit       = hit;
    sel.evicted   = full;
    sel.rand_step = 1'b0;
    if (hit) begin
      victim = hit_way;
    end else if (has_free) begin
      victim = free_way;
    end else begin
      case (policy) inside
        POL_LRU, POL_FIFO: victim = min_way;
        default: begin
          victim        = rand_way;
          sel.rand_step = 1'b1;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/set_assoc_cache_tag_replace_top.sv =====
// Top level of the set-associative tag directory with LRU, FIFO and random replacement.
//
// Input channel (in_valid/in_ready): one access word, in_cmd (0 read, 1 write) and
// in_address. Output channel (out_valid/out_ready): hit, way, evicted and the four
// running counters after that access. Configuration channel (cfg_valid/cfg_ready,
// always ready): cfg_index selects policy (0), offset width (1) or index width (2).
//
// Each access is a read-modify-write of its set row: the accept cycle reads the row from the
// tag RAM, the next cycle compares tags and picks the way, and the row is written back once
// the output register is free. The result is registered at write-back, and a new access is
// taken only after that write-back, set by the single read-modify-write of the tag RAM row.
//
// A finished result waits in the output register; one more access may be accepted
// and looked up meanwhile, and its write-back holds until the output register frees.
//
// After reset a clearing pass writes every set row to zero, one row a cycle; in_ready
// stays low during it. Config writes are taken at all times.
`default_nettype none
module set_assoc_cache_tag_replace_top #(
  parameter int WAYS      = sact_pkg::DEF_WAYS,
  parameter int SETS      = sact_pkg::DEF_SETS,
  parameter int ADDR_BITS = sact_pkg::DEF_ADDR_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // access words
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_cmd,
  input  wire logic [sact_pkg::ADDR_W-1:0]      in_address,
  // result words
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_hit,
  output logic [1:0]                            out_way,
  output logic                                  out_evicted,
  output logic [sact_pkg::CNT_W-1:0]            out_hits_total,
  output logic [sact_pkg::CNT_W-1:0]            out_misses_total,
  output logic [sact_pkg::CNT_W-1:0]            out_reads_total,
  output logic [sact_pkg::CNT_W-1:0]            out_writes_total,
  // configuration writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sact_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sact_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sact_pkg::*;

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W = WAYS * $bits(sact_line_t);
  localparam logic [SET_W-1:0] CLR_LAST = SET_W'(SETS - 1);

  sact_state_t          state_r, state_nxt;
  logic [SET_W-1:0]     clr_idx_r;
  logic [1:0]           policy_r;
  logic [3:0]           offset_r;
  logic [2:0]           index_r;
  logic [CNT_W-1:0]     hit_cnt_r, miss_cnt_r, rd_cnt_r, wr_cnt_r;
  logic [STAMP_W-1:0]   tick_r;
  logic [STAMP_W-1:0]   tick_nxt;
  logic [LFSR_W-1:0]    lfsr_r;
  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [1:0]           out_way_r;
  logic                 out_evicted_r;
  logic [SET_W-1:0]     set_r;
  logic [TAG_W-1:0]     tag_r;
  logic                 cmd_r;

  logic                 accept;
  logic                 commit;
  logic [SET_W-1:0]     split_set;
  logic [TAG_W-1:0]     split_tag;
  logic                 ram_wr_en;
  logic [SET_W-1:0]     ram_wr_addr;
  logic [ROW_W-1:0]     ram_wr_data;
  logic [ROW_W-1:0]     ram_rd_data;
  sact_line_t [WAYS-1:0] row_rd;
  sact_line_t [WAYS-1:0] row_new;
  sact_sel_t            sel;
  logic [WAY_W-1:0]     victim;
  logic [LFSR_W-1:0]    lfsr_step;

  // Address split for the incoming word
  sact_addr_split #(
    .SETS      (SETS),
    .ADDR_BITS (ADDR_BITS)
  ) u_split (
    .address     (in_address),
    .offset_bits (offset_r),
    .index_bits  (index_r),
    .set_idx     (split_set),
    .tag         (split_tag)
  );

  // Tag and stamp RAM, one row per set
  sact_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (accept),
    .rd_addr (split_set),
    .rd_data (ram_rd_data)
  );

  assign row_rd = ram_rd_data;

  // Way selection on the row read back
  sact_victim #(
    .WAYS (WAYS)
  ) u_victim (
    .row       (row_rd),
    .tag       (tag_r),
    .policy    (policy_r),
    .lfsr_cur  (lfsr_r),
    .sel       (sel),
    .victim    (victim),
    .lfsr_step (lfsr_step)
  );

  assign tick_nxt = tick_r + STAMP_W'(1);

  // Build the row to write back
  always_comb begin
    row_new = row_rd;
    if (sel.hit) begin
      if (policy_r == POL_LRU) begin
        row_new[victim].stamp = tick_nxt;
      end
    end else begin
      row_new[victim].valid = 1'b1;
      row_new[victim].tag   = tag_r;
      if ((policy_r == POL_LRU) || (policy_r == POL_FIFO)) begin
        row_new[victim].stamp = tick_nxt;
      end
    end
  end

  // Next state, handshake and RAM write control
  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    accept      = 1'b0;
    commit      = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = set_r;
    ram_wr_data = row_new;
    unique case (state_r)
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_idx_r;
        ram_wr_data = '0;
        if (clr_idx_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        accept   = in_valid;
        if (in_valid) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!out_valid_r || out_ready) begin
          commit    = 1'b1;
          ram_wr_en = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Control state, counters and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      policy_r    <= RST_POLICY;
      offset_r    <= RST_OFFSET;
      index_r     <= RST_INDEX;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      rd_cnt_r    <= '0;
      wr_cnt_r    <= '0;
      tick_r      <= '0;
      lfsr_r      <= LFSR_SEED;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_idx_r <= clr_idx_r + SET_W'(1);
      end
      // Register writes
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_POLICY: policy_r <= cfg_data[1:0];
          CFG_OFFSET: offset_r <= cfg_data[3:0];
          CFG_INDEX:  index_r  <= cfg_data[2:0];
          default: ;
        endcase
      end
      // Advance statistics on write-back
      if (commit) begin
        tick_r <= tick_nxt;
        if (sel.hit) begin
          hit_cnt_r <= hit_cnt_r + CNT_W'(1);
        end else begin
          miss_cnt_r <= miss_cnt_r + CNT_W'(1);
        end
        if (cmd_r) begin
          wr_cnt_r <= wr_cnt_r + CNT_W'(1);
        end else begin
          rd_cnt_r <= rd_cnt_r + CNT_W'(1);
        end
        if (sel.rand_step) begin
          lfsr_r <= lfsr_step;
        end
      end
      // Output word valid
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      set_r <= split_set;
      tag_r <= split_tag;
      cmd_r <= in_cmd;
    end
    if (commit) begin
      out_hit_r     <= sel.hit;
      out_way_r     <= 2'(victim);
      out_evicted_r <= sel.evicted;
    end
  end

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_way          = out_way_r;
  assign out_evicted      = out_evicted_r;
  assign out_hits_total   = hit_cnt_r;
  assign out_misses_total = miss_cnt_r;
  assign out_reads_total  = rd_cnt_r;
  assign out_writes_total = wr_cnt_r;

endmodule
`default_nettype wire

// ===== verif/tag_directory_check.sv =====
// Monitors the access, result and config words and predicts every lookup of the tag directory.
module tag_directory_check
  import sact_pkg::*;
#(
  parameter int WAYS = DEF_WAYS,
  parameter int SETS = DEF_SETS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_cmd,
  input  logic [ADDR_W-1:0]     in_address,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_hit,
  input  logic [1:0]            out_way,
  input  logic                  out_evicted,
  input  logic [CNT_W-1:0]      out_hits_total,
  input  logic [CNT_W-1:0]      out_misses_total,
  input  logic [CNT_W-1:0]      out_reads_total,
  input  logic [CNT_W-1:0]      out_writes_total,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  // floor(log2 SETS): the widest index that still addresses a real set
  localparam int SET_BITS = ((1 << $clog2(SETS)) == SETS) ? $clog2(SETS) : $clog2(SETS) - 1;

  typedef struct packed {
    logic             hit;
    logic [1:0]       way;
    logic             evicted;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] reads;
    logic [CNT_W-1:0] writes;
  } lookup_t;

  // Mirror of the directory and its registers
  logic [1:0]         policy;
  logic [3:0]         offset_bits;
  logic [2:0]         index_bits;
  bit                 dir_valid [SETS][WAYS];
  logic [TAG_W-1:0]   dir_tag   [SETS][WAYS];
  logic [STAMP_W-1:0] dir_stamp [SETS][WAYS];
  logic [STAMP_W-1:0] tick;
  logic [LFSR_W-1:0]  lfsr;
  logic [CNT_W-1:0]   hit_cnt, miss_cnt, read_cnt, write_cnt;

  lookup_t lookup_q [$];

  task automatic clear_directory();
    policy      = RST_POLICY;
    offset_bits = RST_OFFSET;
    index_bits  = RST_INDEX;
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        dir_valid[s][w] = 1'b0;
      end
    end
    tick      = '0;
    lfsr      = LFSR_SEED;
    hit_cnt   = '0;
    miss_cnt  = '0;
    read_cnt  = '0;
    write_cnt = '0;
  endtask

  // Look one address up, update the mirror and return the word the block should send
  task automatic lookup_and_update(input logic cmd, input logic [ADDR_W-1:0] addr,
                                   output lookup_t res);
    int               k;
    int               row;
    int               victim;
    logic [TAG_W-1:0] tag;
    logic [STAMP_W-1:0] oldest;
    bit               hit;
    bit               evicted;
    bit               found;
    bit               lsb;
    k = (int'(index_bits) > SET_BITS) ? SET_BITS : int'(index_bits);
    tick = tick + 1'b1;
    if (cmd) write_cnt = write_cnt + 1'b1;
    else     read_cnt  = read_cnt + 1'b1;

    row = int'((addr >> offset_bits) & ((32'd1 << k) - 32'd1));
    if (row >= SETS) row = 0;
    tag = addr >> (int'(offset_bits) + k);

    hit     = 1'b0;
    evicted = 1'b0;
    victim  = 0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && dir_valid[row][w] && dir_tag[row][w] == tag) begin
        hit    = 1'b1;
        victim = w;
      end
    end

    if (hit) begin
      hit_cnt = hit_cnt + 1'b1;
      if (policy == POL_LRU) dir_stamp[row][victim] = tick;
    end else begin
      miss_cnt = miss_cnt + 1'b1;
      found    = 1'b0;
      // fill the lowest free way first
      for (int w = 0; w < WAYS; w++) begin
        if (!found && !dir_valid[row][w]) begin
          victim = w;
          found  = 1'b1;
        end
      end
      if (!found) begin
        evicted = 1'b1;
        if (policy == POL_LRU || policy == POL_FIFO) begin
          // smallest stamp wins, ties go to the lowest way
          oldest = dir_stamp[row][0];
          victim = 0;
          for (int w = 1; w < WAYS; w++) begin
            if (dir_stamp[row][w] < oldest) begin
              oldest = dir_stamp[row][w];
              victim = w;
            end
          end
        end else begin
          // step the Galois LFSR once per random eviction
          lsb  = lfsr[0];
          lfsr = lfsr >> 1;
          if (lsb) lfsr = lfsr ^ LFSR_TAPS;
          victim = int'(lfsr) % WAYS;
        end
      end
      dir_tag[row][victim]   = tag;
      dir_valid[row][victim] = 1'b1;
      if (policy == POL_LRU || policy == POL_FIFO) dir_stamp[row][victim] = tick;
    end

    res.hit     = hit;
    res.way     = 2'(victim);
    res.evicted = evicted;
    res.hits    = hit_cnt;
    res.misses  = miss_cnt;
    res.reads   = read_cnt;
    res.writes  = write_cnt;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("result mismatch on %s: expected 0x%08h, got 0x%08h at %0t",
                 name, want, got, $realtime);
      mismatches++;
    end
  endtask

  initial begin
    mismatches  = 0;
    outstanding = 0;
    clear_directory();
  end

  // Compare result words, track config writes, predict accepted accesses
  always @(posedge clk) begin
    lookup_t want;
    lookup_t pred;
    if (!rst_n) begin
      clear_directory();
      lookup_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (lookup_q.size() == 0) begin
          if (mismatches < 10)
            $display("result word with no lookup pending at %0t", $realtime);
          mismatches++;
        end else begin
          want = lookup_q.pop_front();
          check_field("hit", 32'(want.hit), 32'(out_hit));
          check_field("way", 32'(want.way), 32'(out_way));
          check_field("evicted", 32'(want.evicted), 32'(out_evicted));
          check_field("hits_total", want.hits, out_hits_total);
          check_field("misses_total", want.misses, out_misses_total);
          check_field("reads_total", want.reads, out_reads_total);
          check_field("writes_total", want.writes, out_writes_total);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_POLICY: policy      = cfg_data[1:0];
          CFG_OFFSET: offset_bits = cfg_data[3:0];
          CFG_INDEX:  index_bits  = cfg_data[2:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        lookup_and_update(in_cmd, in_address, pred);
        lookup_q.push_back(pred);
      end
    end
    outstanding = lookup_q.size();
  end

endmodule

// ===== verif/testbench.sv =====
// Stimulus, reset, clocking and verdict for the set-associative tag directory.
module testbench;
  import sact_pkg::*;

  localparam int          ACCESS_TARGET = 1000;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam logic [1:0]  POL_SPARE     = 2'd3;  // unused code, acts as random
  localparam logic        CMD_READ      = 1'b0;
  localparam logic        CMD_WRITE     = 1'b1;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_cmd;
  logic [ADDR_W-1:0]     in_address;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_hit;
  logic [1:0]            out_way;
  logic                  out_evicted;
  logic [CNT_W-1:0]      out_hits_total;
  logic [CNT_W-1:0]      out_misses_total;
  logic [CNT_W-1:0]      out_reads_total;
  logic [CNT_W-1:0]      out_writes_total;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int outstanding;
  int cycles;
  int accesses_sent;
  int stall_left;
  bit idling;

  set_assoc_cache_tag_replace_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_address       (in_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_way          (out_way),
    .out_evicted      (out_evicted),
    .out_hits_total   (out_hits_total),
    .out_misses_total (out_misses_total),
    .out_reads_total  (out_reads_total),
    .out_writes_total (out_writes_total),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  tag_directory_check monitor (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_address       (in_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_way          (out_way),
    .out_evicted      (out_evicted),
    .out_hits_total   (out_hits_total),
    .out_misses_total (out_misses_total),
    .out_reads_total  (out_reads_total),
    .out_writes_total (out_writes_total),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Gap length: mostly short, now and then long
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 7) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Byte address under the default split: 4 offset bits, 6 index bits
  function automatic logic [31:0] line_addr(logic [21:0] tag, logic [5:0] row, logic [3:0] boff);
    return {tag, row, boff};
  endfunction

  // Stall the result side at random while idling is on
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (idling && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left = pick_gap() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("set_assoc_cache_tag_replace_top regression: fail");
      $finish;
    end
  end

  // Present one access word, hold it until taken
  task automatic send_access(input logic cmd, input logic [31:0] addr);
    int gap;
    gap = (idling && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_address <= addr;
    do @(posedge clk); while (!in_ready);
    accesses_sent++;
  endtask

  // Drop valid and hold off until every pending result has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input sact_cfg_idx_t idx, input logic [3:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [1:0] pol, input logic [3:0] off, input logic [2:0] idx);
    drain();
    write_reg(CFG_POLICY, 4'(pol));
    write_reg(CFG_OFFSET, off);
    write_reg(CFG_INDEX, 4'(idx));
  endtask

  // Four lines into one set, refresh the first, then force an eviction
  task automatic fill_and_evict(input logic [5:0] row);
    for (int t = 1; t <= 4; t++) send_access(CMD_READ, line_addr(22'(t), row, 4'h0));
    send_access(CMD_WRITE, line_addr(22'd1, row, 4'h8));
    send_access(CMD_READ, line_addr(22'd5, row, 4'h0));
  endtask

  initial begin
    logic [31:0] pool [8];
    logic [31:0] base;
    logic [31:0] addr;
    logic [3:0]  off;
    int          count;
    int          r;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_cmd     = CMD_READ;
    in_address = '0;
    out_ready  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_POLICY;
    cfg_data   = '0;
    cycles     = 0;
    accesses_sent = 0;
    stall_left = 0;
    idling     = 1'b0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: address extremes, hit after miss, LRU refresh vs FIFO order
    configure(POL_LRU, 4'd4, 3'd6);
    send_access(CMD_READ, 32'h0000_0000);
    send_access(CMD_WRITE, 32'h0000_0000);
    send_access(CMD_WRITE, 32'hFFFF_FFFF);
    send_access(CMD_READ, 32'hFFFF_FFF0);
    fill_and_evict(6'd5);
    configure(POL_FIFO, 4'd4, 3'd6);
    fill_and_evict(6'd6);

    // Warm up: four distinct tags per set so every way carries a stamp
    configure(POL_LRU, 4'd4, 3'd6);
    idling = 1'b1;
    for (int s = 0; s < 64; s++) begin
      base = $urandom;
      for (int j = 0; j < 4; j++)
        send_access(1'($urandom), line_addr({base[19:0], 2'(j)}, 6'(s), 4'($urandom)));
    end

    // Directed: random eviction, spare policy code, oversized fields, single set
    configure(POL_RANDOM, 4'd4, 3'd6);
    for (int t = 8; t < 12; t++) send_access(CMD_READ, line_addr(22'(t), 6'd7, 4'h0));
    configure(POL_SPARE, 4'd4, 3'd6);
    send_access(CMD_WRITE, line_addr(22'd20, 6'd7, 4'h0));
    send_access(CMD_READ, line_addr(22'd21, 6'd7, 4'h0));
    configure(POL_LRU, 4'd15, 3'd7);
    send_access(CMD_READ, 32'hFFFF_FFFF);
    send_access(CMD_WRITE, 32'hFFFF_FFFF);
    configure(POL_FIFO, 4'd0, 3'd0);
    send_access(CMD_WRITE, 32'h0000_0000);
    send_access(CMD_READ, 32'hFFFF_FFFF);
    send_access(CMD_READ, 32'h0000_0000);
    configure(POL_RANDOM, 4'd8, 3'd6);
    send_access(CMD_READ, 32'hA5A5_A5A5);

    // Random phases: mostly reuse of a small address pool so sets hit and fill
    while (accesses_sent < ACCESS_TARGET) begin
      off = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
      configure(2'($urandom_range(0, 3)), off, 3'($urandom_range(0, 7)));
      idling = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 8; i++) pool[i] = $urandom;
      count = $urandom_range(40, 120);
      for (int n = 0; n < count; n++) begin
        r = $urandom_range(0, 9);
        if (r < 5) addr = pool[$urandom_range(0, 7)];
        else if (r < 8) addr = pool[$urandom_range(0, 7)] ^ ($urandom & 32'h0000_3FF0);
        else addr = $urandom;
        if ($urandom_range(0, 4) == 0) pool[$urandom_range(0, 7)] = $urandom;
        send_access(1'($urandom), addr);
      end
    end

    // Wait out the remaining results, then the pipeline latency
    drain();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("set_assoc_cache_tag_replace_top regression: pass");
    end else begin
      $display("set_assoc_cache_tag_replace_top regression: fail");
    end
    $finish;
  end

endmodule
